// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL of the complex arithmetic unit.
// Included by complex_arith_unit_core, which checks its own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// ante holds in a cycle -> cons holds in the same cycle
`define CAU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// ante holds in a cycle -> cons holds in the next cycle
`define CAU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define CAU_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define CAU_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: rtl/core/cau_pkg.sv
// Shared types and constants of the complex arithmetic unit.
// Used by the step cell, the top level and the testbench; no dependencies.
`default_nettype none

package cau_pkg;

  // quotient bits of the divider, including the rounding bit; also root digit count
  localparam int DIV_STEPS = 33;
  localparam int RAD_W     = 2 * DIV_STEPS;
  localparam int SQ_REM_W  = DIV_STEPS + 2;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4
  } op_t;

  // sideband carried along the chain
  typedef struct packed {
    logic [2:0]  op;
    logic        neg_re;
    logic        neg_im;
    logic        clamp_re;
    logic        clamp_im;
    logic        dz;
    logic [31:0] pre_re;
    logic [31:0] pre_im;
    logic        pre_ovf;
  } side_t;

  // one restoring-divide lane
  typedef struct packed {
    logic [63:0]          rem;
    logic [DIV_STEPS-1:0] num;
    logic [DIV_STEPS-1:0] quo;
  } div_lane_t;

  // one digit-by-digit square root lane
  typedef struct packed {
    logic [RAD_W-1:0]     rad;
    logic [SQ_REM_W-1:0]  rem;
    logic [DIV_STEPS-1:0] root;
  } sqrt_lane_t;

  typedef struct packed {
    side_t      side;
    div_lane_t  re;
    div_lane_t  im;
    logic [63:0] den;
    sqrt_lane_t sq;
  } cell_data_t;

endpackage

`default_nettype wire

// File: rtl/core/cau_cell.sv
// One cell of the divide / square root chain: a quotient bit for both lanes
// and a root bit per cycle while en is high. Depends on cau_pkg.
`default_nettype none

module cau_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  cau_pkg::cell_data_t d_i,
  output logic               vld_o,
  output cau_pkg::cell_data_t d_o
);
  import cau_pkg::*;

  // restoring divide step: shift in next numerator bit, subtract if it fits
  function automatic div_lane_t div_step(div_lane_t l, logic [63:0] den);
    logic [64:0] part;
    logic        ge;
    div_lane_t   o;
    part  = {l.rem, l.num[DIV_STEPS-1]};
    ge    = part >= {1'b0, den};
    o.rem = ge ? 64'(part - {1'b0, den}) : part[63:0];
    o.num = l.num << 1;
    o.quo = {l.quo[DIV_STEPS-2:0], ge};
    return o;
  endfunction

  // square root step: bring down two radicand bits, try root*4+1
  function automatic sqrt_lane_t sqrt_step(sqrt_lane_t l);
    logic [SQ_REM_W+1:0] part;
    logic [SQ_REM_W+1:0] trial;
    logic                ge;
    sqrt_lane_t          o;
    part   = {l.rem, l.rad[RAD_W-1 -: 2]};
    trial  = (SQ_REM_W+2)'({l.root, 2'b01});
    ge     = part >= trial;
    o.rem  = ge ? SQ_REM_W'(part - trial) : part[SQ_REM_W-1:0];
    o.rad  = l.rad << 2;
    o.root = {l.root[DIV_STEPS-2:0], ge};
    return o;
  endfunction

  logic       vld_r;
  cell_data_t d_r;
  cell_data_t d_nxt;

  // step logic
  always_comb begin
    d_nxt    = d_i;
    d_nxt.re = div_step(d_i.re, d_i.den);
    d_nxt.im = div_step(d_i.im, d_i.den);
    d_nxt.sq = sqrt_step(d_i.sq);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end

  assign vld_o = vld_r;
  assign d_o   = d_r;

endmodule

`default_nettype wire

// File: rtl/core/complex_arith_unit_core.sv
// Top level of the complex arithmetic unit: operand stages plus the cell chain.
// Depends on cau_pkg, cau_cell and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

// Complex ALU on signed Q16.16 (FRAC_BITS fraction bits): add, subtract, multiply,
// divide and modulus of a. It takes one word per cycle while in_stall is low; each
// result passes one multiplier stage, one sum stage, one sign/magnitude stage, one
// rounding/setup stage, a chain of 33 cells that each produce one quotient bit
// of both divide lanes and one bit of the root, and the output register. The
// whole pipeline moves together and holds only while a finished word waits
// on a stalled output. Divide by zero gives zeros with out_div_zero set;
// saturated results set out_overflowed.
module complex_arith_unit_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_opcode,
  input  logic signed [31:0] in_a_re,
  input  logic signed [31:0] in_a_im,
  input  logic signed [31:0] in_b_re,
  input  logic signed [31:0] in_b_im,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_r_re,
  output logic signed [31:0] out_r_im,
  output logic               out_div_zero,
  output logic               out_overflowed
);
  import cau_pkg::*;

  localparam int SH = 32 - FRAC_BITS;
  localparam logic [64:0] RND_HALF = 65'(1) << (FRAC_BITS - 1);

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } sat_t;

  // saturate a sign/magnitude value to 32 bits
  function automatic sat_t sat(logic neg, logic [63:0] mag);
    logic [63:0] m;
    sat_t        o;
    m     = mag;
    o.ovf = 1'b0;
    if (!neg && mag > 64'h7FFF_FFFF) begin
      o.ovf = 1'b1;
      m     = 64'h7FFF_FFFF;
    end else if (neg && mag > 64'h8000_0000) begin
      o.ovf = 1'b1;
      m     = 64'h8000_0000;
    end
    o.val = neg ? (~m[31:0] + 32'd1) : m[31:0];
    return o;
  endfunction

  function automatic logic [63:0] mag33(logic signed [32:0] v);
    logic [32:0] m;
    m = v[32] ? 33'(-v) : 33'(v);
    return 64'(m);
  endfunction

  // global advance: hold only when the output word is stalled
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // stage 1: products and add/sub sums
  logic signed [31:0] mb_re, mb_im;
  logic signed [63:0] p_rr_nxt, p_ii_nxt, p_ri_nxt, p_ir_nxt, d_rr_nxt, d_ii_nxt;
  logic signed [32:0] as_re_nxt, as_im_nxt;

  logic               s1_vld_r;
  logic [2:0]         s1_op_r;
  logic signed [63:0] s1_p_rr_r, s1_p_ii_r, s1_p_ri_r, s1_p_ir_r;
  logic [63:0]        s1_d_rr_r, s1_d_ii_r;
  logic signed [32:0] s1_as_re_r, s1_as_im_r;

  always_comb begin
    // modulus squares a through the same two multipliers
    mb_re    = (in_opcode == OP_MOD) ? in_a_re : in_b_re;
    mb_im    = (in_opcode == OP_MOD) ? in_a_im : in_b_im;
    p_rr_nxt = in_a_re * mb_re;
    p_ii_nxt = in_a_im * mb_im;
    p_ri_nxt = in_a_re * in_b_im;
    p_ir_nxt = in_a_im * in_b_re;
    d_rr_nxt = in_b_re * in_b_re;
    d_ii_nxt = in_b_im * in_b_im;
    if (in_opcode == OP_SUB) begin
      as_re_nxt = {in_a_re[31], in_a_re} - {in_b_re[31], in_b_re};
      as_im_nxt = {in_a_im[31], in_a_im} - {in_b_im[31], in_b_im};
    end else begin
      as_re_nxt = {in_a_re[31], in_a_re} + {in_b_re[31], in_b_re};
      as_im_nxt = {in_a_im[31], in_a_im} + {in_b_im[31], in_b_im};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op_r    <= in_opcode;
      s1_p_rr_r  <= p_rr_nxt;
      s1_p_ii_r  <= p_ii_nxt;
      s1_p_ri_r  <= p_ri_nxt;
      s1_p_ir_r  <= p_ir_nxt;
      s1_d_rr_r  <= d_rr_nxt;
      s1_d_ii_r  <= d_ii_nxt;
      s1_as_re_r <= as_re_nxt;
      s1_as_im_r <= as_im_nxt;
    end
  end

  // stage 2: cross-product sums, divisor, add/sub saturation
  logic signed [64:0] p_rr_x, p_ii_x, p_ri_x, p_ir_x;
  logic signed [64:0] sum_re_nxt, sum_im_nxt;
  sat_t               as_re_sat, as_im_sat;

  logic               s2_vld_r;
  logic [2:0]         s2_op_r;
  logic signed [64:0] s2_sum_re_r, s2_sum_im_r;
  logic [63:0]        s2_den_r;
  logic [31:0]        s2_pre_re_r, s2_pre_im_r;
  logic               s2_pre_ovf_r;

  always_comb begin
    p_rr_x = {s1_p_rr_r[63], s1_p_rr_r};
    p_ii_x = {s1_p_ii_r[63], s1_p_ii_r};
    p_ri_x = {s1_p_ri_r[63], s1_p_ri_r};
    p_ir_x = {s1_p_ir_r[63], s1_p_ir_r};
    if (s1_op_r == OP_MUL) begin
      sum_re_nxt = p_rr_x - p_ii_x;
      sum_im_nxt = p_ri_x + p_ir_x;
    end else begin
      sum_re_nxt = p_rr_x + p_ii_x;
      sum_im_nxt = p_ir_x - p_ri_x;
    end
    as_re_sat = sat(s1_as_re_r[32], mag33(s1_as_re_r));
    as_im_sat = sat(s1_as_im_r[32], mag33(s1_as_im_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_op_r     <= s1_op_r;
      s2_sum_re_r <= sum_re_nxt;
      s2_sum_im_r <= sum_im_nxt;
      s2_den_r    <= s1_d_rr_r + s1_d_ii_r;
      if (s1_op_r == OP_ADD || s1_op_r == OP_SUB) begin
        s2_pre_re_r  <= as_re_sat.val;
        s2_pre_im_r  <= as_im_sat.val;
        s2_pre_ovf_r <= as_re_sat.ovf | as_im_sat.ovf;
      end else begin
        s2_pre_re_r  <= '0;
        s2_pre_im_r  <= '0;
        s2_pre_ovf_r <= 1'b0;
      end
    end
  end

  // stage 3: sign and magnitude, zero divisor
  logic        s3_vld_r;
  logic [2:0]  s3_op_r;
  logic        s3_neg_re_r, s3_neg_im_r;
  logic [63:0] s3_mag_re_r, s3_mag_im_r;
  logic [63:0] s3_den_r;
  logic        s3_dz_r;
  logic [31:0] s3_pre_re_r, s3_pre_im_r;
  logic        s3_pre_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_op_r      <= s2_op_r;
      s3_neg_re_r  <= s2_sum_re_r[64];
      s3_neg_im_r  <= s2_sum_im_r[64];
      s3_mag_re_r  <= s2_sum_re_r[64] ? 64'(-s2_sum_re_r) : s2_sum_re_r[63:0];
      s3_mag_im_r  <= s2_sum_im_r[64] ? 64'(-s2_sum_im_r) : s2_sum_im_r[63:0];
      s3_den_r     <= s2_den_r;
      s3_dz_r      <= (s2_op_r == OP_DIV) && (s2_den_r == '0);
      s3_pre_re_r  <= s2_pre_re_r;
      s3_pre_im_r  <= s2_pre_im_r;
      s3_pre_ovf_r <= s2_pre_ovf_r;
    end
  end

  // stage 4: multiply rounding, divide range check, chain setup
  logic [64:0]    rnd_re, rnd_im;
  sat_t           mul_re, mul_im;
  logic [63+SH:0] den_sh;
  cell_data_t     c0_nxt;
  logic           c0_vld_r;
  cell_data_t     c0_r;

  always_comb begin
    rnd_re = ({1'b0, s3_mag_re_r} + RND_HALF) >> FRAC_BITS;
    rnd_im = ({1'b0, s3_mag_im_r} + RND_HALF) >> FRAC_BITS;
    mul_re = sat(s3_neg_re_r, rnd_re[63:0]);
    mul_im = sat(s3_neg_im_r, rnd_im[63:0]);
    den_sh = (64+SH)'(s3_den_r) << SH;

    c0_nxt.side.op       = s3_op_r;
    c0_nxt.side.neg_re   = s3_neg_re_r;
    c0_nxt.side.neg_im   = s3_neg_im_r;
    // quotient would not fit: saturates
    c0_nxt.side.clamp_re = (64+SH)'(s3_mag_re_r) >= den_sh;
    c0_nxt.side.clamp_im = (64+SH)'(s3_mag_im_r) >= den_sh;
    c0_nxt.side.dz       = s3_dz_r;
    if (s3_op_r == OP_MUL) begin
      c0_nxt.side.pre_re  = mul_re.val;
      c0_nxt.side.pre_im  = mul_im.val;
      c0_nxt.side.pre_ovf = mul_re.ovf | mul_im.ovf;
    end else begin
      c0_nxt.side.pre_re  = s3_pre_re_r;
      c0_nxt.side.pre_im  = s3_pre_im_r;
      c0_nxt.side.pre_ovf = s3_pre_ovf_r;
    end

    // numerator scaled by 2^(FRAC_BITS+1): high part seeds the remainder
    c0_nxt.re.rem = s3_mag_re_r >> SH;
    c0_nxt.re.num = DIV_STEPS'(s3_mag_re_r << (FRAC_BITS + 1));
    c0_nxt.re.quo = '0;
    c0_nxt.im.rem = s3_mag_im_r >> SH;
    c0_nxt.im.num = DIV_STEPS'(s3_mag_im_r << (FRAC_BITS + 1));
    c0_nxt.im.quo = '0;
    c0_nxt.den    = s3_den_r;

    c0_nxt.sq.rad  = RAD_W'(s3_mag_re_r);
    c0_nxt.sq.rem  = '0;
    c0_nxt.sq.root = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_vld_r <= 1'b0;
    end else if (adv) begin
      c0_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c0_r <= c0_nxt;
    end
  end

  // cell chain
  logic [DIV_STEPS:0] chain_vld;
  cell_data_t         chain_d [DIV_STEPS+1];

  assign chain_vld[0] = c0_vld_r;
  assign chain_d[0]   = c0_r;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    cau_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (adv),
      .vld_i (chain_vld[i]),
      .d_i   (chain_d[i]),
      .vld_o (chain_vld[i+1]),
      .d_o   (chain_d[i+1])
    );
  end

  // final rounding and result select
  cell_data_t last;
  logic [DIV_STEPS:0] q_re_p1, q_im_p1;
  logic [DIV_STEPS:0] root_rnd;
  sat_t        div_re, div_im, mod_sat;
  logic [31:0] out_r_re_nxt, out_r_im_nxt;
  logic        out_div_zero_nxt, out_overflowed_nxt;

  logic        out_valid_r;
  logic [31:0] out_r_re_r, out_r_im_r;
  logic        out_div_zero_r, out_overflowed_r;

  always_comb begin
    last     = chain_d[DIV_STEPS];
    q_re_p1  = (DIV_STEPS+1)'(last.re.quo) + 1'b1;
    q_im_p1  = (DIV_STEPS+1)'(last.im.quo) + 1'b1;
    div_re   = sat(last.side.neg_re,
                   last.side.clamp_re ? 64'h100_0000_0000 : 64'(q_re_p1[DIV_STEPS:1]));
    div_im   = sat(last.side.neg_im,
                   last.side.clamp_im ? 64'h100_0000_0000 : 64'(q_im_p1[DIV_STEPS:1]));
    root_rnd = (DIV_STEPS+1)'(last.sq.root)
             + (DIV_STEPS+1)'(last.sq.rem > SQ_REM_W'(last.sq.root));
    mod_sat  = sat(1'b0, 64'(root_rnd));

    out_r_re_nxt       = '0;
    out_r_im_nxt       = '0;
    out_div_zero_nxt   = 1'b0;
    out_overflowed_nxt = 1'b0;
    case (op_t'(last.side.op))
      OP_ADD, OP_SUB, OP_MUL: begin
        out_r_re_nxt       = last.side.pre_re;
        out_r_im_nxt       = last.side.pre_im;
        out_overflowed_nxt = last.side.pre_ovf;
      end
      OP_DIV: begin
        if (last.side.dz) begin
          out_div_zero_nxt = 1'b1;
        end else begin
          out_r_re_nxt       = div_re.val;
          out_r_im_nxt       = div_im.val;
          out_overflowed_nxt = div_re.ovf | div_im.ovf;
        end
      end
      OP_MOD: begin
        out_r_re_nxt       = mod_sat.val;
        out_overflowed_nxt = mod_sat.ovf;
      end
      default: begin
        out_r_re_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain_vld[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r_re_r       <= out_r_re_nxt;
      out_r_im_r       <= out_r_im_nxt;
      out_div_zero_r   <= out_div_zero_nxt;
      out_overflowed_r <= out_overflowed_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_r_re       = out_r_re_r;
  assign out_r_im       = out_r_im_r;
  assign out_div_zero   = out_div_zero_r;
  assign out_overflowed = out_overflowed_r;

  // checks
  `CAU_ASSERT_NXT(a_stall_freezes_chain, clk, rst_n, out_valid && out_stall, $stable(chain_vld))
  `CAU_ASSERT_IMP(a_dz_gives_zero, clk, rst_n, out_valid && out_div_zero, out_r_re == 0 && out_r_im == 0 && !out_overflowed)
  `CAU_ASSERT_IMP(a_root_rem_bound, clk, rst_n, chain_vld[DIV_STEPS] && last.side.op == OP_MOD, last.sq.rem <= {1'b0, last.sq.root, 1'b0})
  `CAU_ASSERT_IMP(a_div_rem_below_den, clk, rst_n, chain_vld[DIV_STEPS] && last.side.op == OP_DIV && !last.side.dz && !last.side.clamp_re, last.re.rem < last.den)

endmodule

`default_nettype wire

// File: tb/complex_arith_unit_core_tb.sv
// Self-checking testbench for complex_arith_unit_core: directed and random words,
// predicted in exact fixed point and compared field by field. Depends on cau_pkg and complex_arith_unit_core.
`default_nettype none

module complex_arith_unit_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  localparam int FB = 16;
  localparam longint unsigned POS_LIM = 64'h7FFF_FFFF;
  localparam longint unsigned NEG_LIM = 64'h8000_0000;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        dz;
    logic        ovf;
  } cplx_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_opcode = '0;
  logic signed [31:0] in_a_re = '0, in_a_im = '0, in_b_re = '0, in_b_im = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_r_re, out_r_im;
  logic out_div_zero, out_overflowed;

  cplx_res_t pending_results[$];
  int err_count = 0;
  int burst_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  complex_arith_unit_core #(.FRAC_BITS(FB)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_a_re(in_a_re), .in_a_im(in_a_im), .in_b_re(in_b_re), .in_b_im(in_b_im),
    .out_valid(out_valid), .out_stall(out_stall), .out_r_re(out_r_re),
    .out_r_im(out_r_im), .out_div_zero(out_div_zero), .out_overflowed(out_overflowed)
  );

  // signed magnitude to saturated 32-bit part
  function automatic logic [31:0] sat_part(bit neg, longint unsigned mag, inout bit ovf);
    if (!neg && mag > POS_LIM) begin
      ovf = 1'b1;
      mag = POS_LIM;
    end else if (neg && mag > NEG_LIM) begin
      ovf = 1'b1;
      mag = NEG_LIM;
    end
    return neg ? 32'(-mag) : 32'(mag);
  endfunction

  // round(n * 2^FB / d), ties away from zero
  function automatic longint unsigned quot_round(longint unsigned n, longint unsigned d);
    longint unsigned q, rem;
    q = n / d;
    rem = n % d;
    if (q >= (64'd1 << (32 - FB))) return 64'd1 << 40;
    for (int i = 0; i <= FB; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q = q | 64'd1;
      end
    end
    return (q + 64'd1) >> 1;
  endfunction

  function automatic longint unsigned root_round(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (n > r) r++;
    return r;
  endfunction

  // exact sum of two products as signed 66-bit, then magnitude
  function automatic cplx_res_t predict_cplx(logic [2:0] op, logic signed [31:0] ar,
      logic signed [31:0] ai, logic signed [31:0] br, logic signed [31:0] bi);
    cplx_res_t r;
    bit ovf;
    logic signed [65:0] sr, si;
    longint unsigned den, mr, mi;
    r = '0;
    ovf = 1'b0;
    case (op)
      OP_ADD, OP_SUB: begin
        sr = (op == OP_ADD) ? 66'(ar) + 66'(br) : 66'(ar) - 66'(br);
        si = (op == OP_ADD) ? 66'(ai) + 66'(bi) : 66'(ai) - 66'(bi);
        r.re = sat_part(sr < 0, 64'(sr < 0 ? -sr : sr), ovf);
        r.im = sat_part(si < 0, 64'(si < 0 ? -si : si), ovf);
      end
      OP_MUL: begin
        sr = 66'(ar) * 66'(br) - 66'(ai) * 66'(bi);
        si = 66'(ar) * 66'(bi) + 66'(ai) * 66'(br);
        mr = 64'(sr < 0 ? -sr : sr);
        mi = 64'(si < 0 ? -si : si);
        r.re = sat_part(sr < 0, (mr + (64'd1 << (FB - 1))) >> FB, ovf);
        r.im = sat_part(si < 0, (mi + (64'd1 << (FB - 1))) >> FB, ovf);
      end
      OP_DIV: begin
        den = 64'(66'(br) * 66'(br) + 66'(bi) * 66'(bi));
        if (den == 0) begin
          r.dz = 1'b1;
        end else begin
          sr = 66'(ar) * 66'(br) + 66'(ai) * 66'(bi);
          si = 66'(ai) * 66'(br) - 66'(ar) * 66'(bi);
          r.re = sat_part(sr < 0, quot_round(64'(sr < 0 ? -sr : sr), den), ovf);
          r.im = sat_part(si < 0, quot_round(64'(si < 0 ? -si : si), den), ovf);
        end
      end
      OP_MOD: begin
        den = 64'(66'(ar) * 66'(ar) + 66'(ai) * 66'(ai));
        r.re = sat_part(1'b0, root_round(den), ovf);
      end
      default: ;
    endcase
    r.ovf = ovf;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    err_count++;
  endtask

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    cplx_res_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", out_r_re, 32'h0);
      end else begin
        w = pending_results.pop_front();
        if (out_r_re !== w.re) report_mismatch("r_re", out_r_re, w.re);
        if (out_r_im !== w.im) report_mismatch("r_im", out_r_im, w.im);
        if (out_div_zero !== w.dz) report_mismatch("div_zero", out_div_zero, w.dz);
        if (out_overflowed !== w.ovf) report_mismatch("overflowed", out_overflowed, w.ovf);
      end
    end
  end

  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase++;
    // long quiet windows, then bursty stalls
    if ((stall_phase / 300) % 3 == 0) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 99) < 35);
  end

  // send one word, with bursts and random gaps in front
  task automatic send_word(logic [2:0] op, logic [31:0] ar, logic [31:0] ai,
      logic [31:0] br, logic [31:0] bi);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_opcode <= op;
    in_a_re <= ar;
    in_a_im <= ai;
    in_b_re <= br;
    in_b_im <= bi;
    pending_results.push_back(predict_cplx(op, ar, ai, br, bi));
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_until_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      3: return 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23));
      4: return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed_ops();
    logic [31:0] ext[4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
    for (int op = 0; op < 5; op++) begin
      send_word(3'(op), ext[0], ext[1], ext[1], ext[0]);
      send_word(3'(op), ext[1], ext[1], ext[1], ext[1]);
      send_word(3'(op), 32'h0001_8000, 32'hFFFE_8000, 32'h0000_8000, 32'h0003_0000);
    end
    // zero divisor, zero numerator too
    send_word(OP_DIV, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
    send_word(OP_DIV, 32'h0, 32'h0, 32'h0, 32'h0);
    // tiny divisor saturates
    send_word(OP_DIV, 32'h7FFF_FFFF, 32'h0, 32'h0000_0001, 32'h0);
    // unused opcodes give zeros
    send_word(3'd5, ext[0], ext[0], ext[0], ext[0]);
    send_word(3'd6, ext[1], ext[3], ext[0], ext[1]);
    send_word(3'd7, ext[3], ext[3], ext[3], ext[3]);
    idle_until_drained();
  endtask

  task automatic test_random_mix();
    logic [2:0] op;
    for (int i = 0; i < 850; i++) begin
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      if (op == OP_DIV && $urandom_range(0, 15) == 0)
        send_word(op, rand_operand(), rand_operand(), 32'h0, 32'h0);
      else
        send_word(op, rand_operand(), rand_operand(), rand_operand(), rand_operand());
      if (i == 400) idle_until_drained();
    end
    idle_until_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_ops();
    test_random_mix();
    repeat (60) @(negedge clk);
    if (err_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

// File: complex_arith_unit_core.f
+incdir+rtl/core
rtl/core/cau_pkg.sv
rtl/core/cau_cell.sv
rtl/core/complex_arith_unit_core.sv
tb/complex_arith_unit_core_tb.sv
